[hdl/gsbo_pkg.sv]
package gsbo_pkg;

	// Timing numerators, Q24 seconds at unit speed
	localparam logic [23:0] ENTER_K   = 24'd9227469;
	localparam logic [23:0] EXIT_K    = 24'd7549747;
	localparam logic [23:0] STAG_K    = 24'd1677722;
	localparam logic [14:0] GAP_Q     = 15'd19661;
	localparam logic [9:0]  SPEED_MIN = 10'd26;

	// Ease-out-back and hop coefficients
	localparam logic [18:0] C1_BASE  = 19'd33454;
	localparam logic [17:0] C1_SLOPE = 18'd189575;
	localparam logic [13:0] HOP_K    = 14'd11796;
	localparam logic [63:0] PI_Q30   = 64'd3373259422;

	// Widths of derived timing values
	localparam int DUR_W  = 19;
	localparam int STAG_W = 17;
	localparam int SPAN_W = 25;
	localparam int HEND_W = 26;
	localparam int CYC_W  = 27;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_ENTER = 3'd1,
		PH_HELD  = 3'd2,
		PH_EXIT  = 3'd3,
		PH_GONE  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		REG_DIRECTION = 3'd0,
		REG_SPEED     = 3'd1,
		REG_BOUNCE    = 3'd2,
		REG_HOLD      = 3'd3,
		REG_WIDTH     = 3'd4,
		REG_HEIGHT    = 3'd5,
		REG_GLYPHS    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [12:0] gx;
		logic [12:0] gy;
	} glyph_t;

	typedef struct packed {
		logic signed [14:0] pos_x;
		logic signed [13:0] pos_y;
		phase_t             phase;
	} result_t;

endpackage

[hdl/glyph_slide_bounce_offset.sv]
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+----------------------------------
// config    | in        | cfg_we              | cfg_index, cfg_data
// glyph in  | in        | in_valid / in_ready | time_s, glyph_index, glyph_x, glyph_y
// result    | out       | out_valid/out_ready | pos_x, pos_y, phase
//
// One request per cycle while in_ready is high; the pipeline has 32 modulo
// steps, 16 progress divide steps, multiply and round stages, then a
// two-entry output buffer. After reset and after every config write a setup
// sequencer runs (a shared-counter divider for the timings, then the sums);
// in_ready is low meanwhile. The pipeline advances as a whole whenever the
// output buffer has room, so a waiting result does not block the next request.
module glyph_slide_bounce_offset #(
	parameter int MAX_GLYPHS   = 256,
	parameter int SINE_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        time_s,
	input  logic [7:0]         glyph_index,
	input  logic [12:0]        glyph_x,
	input  logic [12:0]        glyph_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] pos_x,
	output logic signed [13:0] pos_y,
	output logic [2:0]         phase
);

	localparam int NST = 58;
	localparam int KW  = $clog2(SINE_ENTRIES);
	localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	typedef enum logic [5:0] {
		ST_LOAD = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_SPAN = 6'b000100,
		ST_HEND = 6'b001000,
		ST_CYC  = 6'b010000,
		ST_IDLE = 6'b100000
	} setup_state_t;

	// Sine table entry over the half period, folded about pi/2
	function automatic logic [15:0] sine_entry(input int unsigned k);
		logic [63:0] kk;
		logic [63:0] x;
		logic [63:0] term;
		logic signed [63:0] sum;
		kk = 64'(k);
		if (2 * kk > 64'(SINE_ENTRIES)) begin
			kk = 64'(SINE_ENTRIES) - kk;
		end
		x = gsbo_pkg::PI_Q30 * kk / SINE_ENTRIES;
		sum = $signed(x);
		term = x;
		for (int i = 1; i <= 7; i++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / TAYLOR_DIV[i];
			if (i[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return 16'(($unsigned(sum) + 64'd16384) >> 15);
	endfunction

	// Round to nearest, ties away from zero, then clamp
	function automatic logic signed [55:0] round_sat(input logic signed [55:0] v,
		input int unsigned sh, input logic signed [55:0] lo, input logic signed [55:0] hi);
		logic [55:0] mag;
		logic [55:0] r;
		logic signed [55:0] q;
		mag = v[55] ? 56'(-v) : 56'(v);
		r = (mag + (56'd1 << (sh - 1))) >> sh;
		q = v[55] ? -$signed(r) : $signed(r);
		if (q < lo) begin
			q = lo;
		end else if (q > hi) begin
			q = hi;
		end
		return q;
	endfunction

	// ---------------- configuration registers ----------------
	logic        cfg_dir_q;
	logic [9:0]  cfg_speed_q;
	logic [8:0]  cfg_bounce_q;
	logic [10:0] cfg_hold_q;
	logic [12:0] cfg_width_q;
	logic [11:0] cfg_height_q;
	logic [8:0]  cfg_glyphs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dir_q    <= 1'b0;
			cfg_speed_q  <= 10'd256;
			cfg_bounce_q <= 9'd154;
			cfg_hold_q   <= 11'd384;
			cfg_width_q  <= 13'd1920;
			cfg_height_q <= 12'd64;
			cfg_glyphs_q <= 9'd1;
		end else if (cfg_we) begin
			unique case (gsbo_pkg::cfg_idx_t'(cfg_index))
				gsbo_pkg::REG_DIRECTION: cfg_dir_q    <= cfg_data[0];
				gsbo_pkg::REG_SPEED:     cfg_speed_q  <= cfg_data[9:0];
				gsbo_pkg::REG_BOUNCE:    cfg_bounce_q <= cfg_data[8:0];
				gsbo_pkg::REG_HOLD:      cfg_hold_q   <= cfg_data[10:0];
				gsbo_pkg::REG_WIDTH:     cfg_width_q  <= cfg_data[12:0];
				gsbo_pkg::REG_HEIGHT:    cfg_height_q <= cfg_data[11:0];
				gsbo_pkg::REG_GLYPHS:    cfg_glyphs_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// ---------------- setup sequencer ----------------
	setup_state_t state_q;
	logic [4:0]   cnt_q;
	logic [23:0]  num_q  [3];
	logic [9:0]   drem_q [3];
	logic [23:0]  dquo_q [3];

	logic [gsbo_pkg::DUR_W-1:0]  enter_q;
	logic [gsbo_pkg::DUR_W-1:0]  exit_q;
	logic [gsbo_pkg::STAG_W-1:0] stag_q;
	logic [gsbo_pkg::SPAN_W-1:0] span_q;
	logic [gsbo_pkg::HEND_W-1:0] dwell_end_q;
	logic [gsbo_pkg::CYC_W-1:0]  cycle_q;
	logic [18:0]                 c1_q;
	logic [25:0]                 hk1_q;
	logic [34:0]                 hk_q;

	logic [9:0] sp;
	logic [8:0] n_clamped;
	logic [8:0] nm1;

	// Clamp speed and glyph count
	always_comb begin
		sp = (cfg_speed_q < gsbo_pkg::SPEED_MIN) ? gsbo_pkg::SPEED_MIN : cfg_speed_q;
		if (cfg_glyphs_q == 9'd0) begin
			n_clamped = 9'd1;
		end else if (int'(cfg_glyphs_q) > MAX_GLYPHS) begin
			n_clamped = 9'(MAX_GLYPHS);
		end else begin
			n_clamped = cfg_glyphs_q;
		end
		nm1 = n_clamped - 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: state_q <= ST_HEND;
				ST_HEND: state_q <= ST_CYC;
				ST_CYC:  state_q <= ST_IDLE;
				ST_IDLE: state_q <= ST_IDLE;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Rounded timing divides, one quotient bit per cycle, then the sums
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			num_q[0] <= gsbo_pkg::ENTER_K + 24'(sp >> 1);
			num_q[1] <= gsbo_pkg::EXIT_K + 24'(sp >> 1);
			num_q[2] <= gsbo_pkg::STAG_K + 24'(sp >> 1);
			for (int j = 0; j < 3; j++) begin
				drem_q[j] <= '0;
				dquo_q[j] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			for (int j = 0; j < 3; j++) begin
				if ({drem_q[j], num_q[j][23]} >= {1'b0, sp}) begin
					drem_q[j] <= 10'({drem_q[j], num_q[j][23]} - {1'b0, sp});
					dquo_q[j] <= {dquo_q[j][22:0], 1'b1};
				end else begin
					drem_q[j] <= {drem_q[j][8:0], num_q[j][23]};
					dquo_q[j] <= {dquo_q[j][22:0], 1'b0};
				end
				num_q[j] <= {num_q[j][22:0], 1'b0};
			end
		end
		if (state_q == ST_SPAN) begin
			enter_q <= dquo_q[0][gsbo_pkg::DUR_W-1:0];
			exit_q  <= dquo_q[1][gsbo_pkg::DUR_W-1:0];
			stag_q  <= dquo_q[2][gsbo_pkg::STAG_W-1:0];
			span_q  <= gsbo_pkg::SPAN_W'(26'(nm1) * 26'(dquo_q[2][gsbo_pkg::STAG_W-1:0]));
			c1_q    <= gsbo_pkg::C1_BASE
				+ 19'((27'(gsbo_pkg::C1_SLOPE) * 27'(cfg_bounce_q) + 27'd128) >> 8);
			hk1_q   <= 26'(cfg_height_q) * 26'(gsbo_pkg::HOP_K);
		end
		if (state_q == ST_HEND) begin
			dwell_end_q <= gsbo_pkg::HEND_W'(span_q) + gsbo_pkg::HEND_W'(enter_q)
				+ gsbo_pkg::HEND_W'({cfg_hold_q, 8'd0});
			hk_q <= 35'(hk1_q) * 35'(cfg_bounce_q);
		end
		if (state_q == ST_CYC) begin
			cycle_q <= gsbo_pkg::CYC_W'(dwell_end_q) + gsbo_pkg::CYC_W'(span_q)
				+ gsbo_pkg::CYC_W'(exit_q) + gsbo_pkg::CYC_W'(gsbo_pkg::GAP_Q);
		end
	end

	// ---------------- sine table ----------------
	logic [15:0] sine_rom [SINE_ENTRIES];
	for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
		assign sine_rom[k] = sine_entry(k);
	end

	// ---------------- pipeline control ----------------
	logic [1:0]      fcnt_q;
	logic            wptr_q;
	logic            rptr_q;
	gsbo_pkg::result_t fifo_q [2];
	gsbo_pkg::result_t res_c;
	logic            adv;
	logic            push;
	logic            pop;
	logic [NST-1:0]  vld_q;

	assign adv      = (fcnt_q != 2'd2) || out_ready;
	assign in_ready = adv && (state_q == ST_IDLE);
	assign push     = adv && vld_q[NST-1];
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid && in_ready};
		end
	end

	// ---------------- time modulo cycle, one bit per stage ----------------
	logic [gsbo_pkg::CYC_W-1:0] mod_rem_s [32];
	logic [31:0]                mod_t_s   [32];
	logic [7:0]                 mod_idx_s [32];
	gsbo_pkg::glyph_t           mod_pos_s [32];

	for (genvar k = 0; k < 32; k++) begin : g_mod
		logic [gsbo_pkg::CYC_W-1:0] rem_in;
		logic [31:0]                t_in;
		logic [7:0]                 idx_in;
		gsbo_pkg::glyph_t           pos_in;
		logic [gsbo_pkg::CYC_W:0]   trial;
		if (k == 0) begin : g_head
			assign rem_in = '0;
			assign t_in   = time_s;
			assign idx_in = glyph_index;
			assign pos_in = '{gx: glyph_x, gy: glyph_y};
		end else begin : g_body
			assign rem_in = mod_rem_s[k-1];
			assign t_in   = mod_t_s[k-1];
			assign idx_in = mod_idx_s[k-1];
			assign pos_in = mod_pos_s[k-1];
		end
		assign trial = {rem_in, t_in[31]};
		always_ff @(posedge clk) begin
			if (adv) begin
				if (trial >= {1'b0, cycle_q}) begin
					mod_rem_s[k] <= gsbo_pkg::CYC_W'(trial - {1'b0, cycle_q});
				end else begin
					mod_rem_s[k] <= trial[gsbo_pkg::CYC_W-1:0];
				end
				mod_t_s[k]   <= {t_in[30:0], 1'b0};
				mod_idx_s[k] <= idx_in;
				mod_pos_s[k] <= pos_in;
			end
		end
	end

	// ---------------- stage 32..34: glyph window and phase ----------------
	logic [gsbo_pkg::CYC_W-1:0] lt_s32;
	logic [24:0]                es_s32;
	gsbo_pkg::glyph_t           pos_s32;
	logic [28:0]                d_s33;
	logic [28:0]                dh_s33;
	gsbo_pkg::glyph_t           pos_s33;
	gsbo_pkg::phase_t           ph_s34;
	logic [18:0]                elap_s34;
	logic [18:0]                den_s34;
	gsbo_pkg::glyph_t           pos_s34;
	gsbo_pkg::phase_t           ph_c;
	logic [18:0]                elap_c;
	logic [18:0]                den_c;

	// Classify against the entry, hold and exit windows
	always_comb begin
		ph_c   = gsbo_pkg::PH_WAIT;
		elap_c = '0;
		den_c  = enter_q;
		if (d_s33[28]) begin
			ph_c = gsbo_pkg::PH_WAIT;
		end else if (d_s33[27:0] < 28'(enter_q)) begin
			ph_c   = gsbo_pkg::PH_ENTER;
			elap_c = d_s33[18:0];
		end else if (dh_s33[28]) begin
			ph_c = gsbo_pkg::PH_HELD;
		end else if (dh_s33[27:0] < 28'(exit_q)) begin
			ph_c   = gsbo_pkg::PH_EXIT;
			elap_c = dh_s33[18:0];
			den_c  = exit_q;
		end else begin
			ph_c = gsbo_pkg::PH_GONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lt_s32   <= mod_rem_s[31];
			es_s32   <= 25'(mod_idx_s[31]) * 25'(stag_q);
			pos_s32  <= mod_pos_s[31];
			d_s33    <= 29'(lt_s32) - 29'(es_s32);
			dh_s33   <= 29'(lt_s32) - 29'(es_s32) - 29'(dwell_end_q);
			pos_s33  <= pos_s32;
			ph_s34   <= ph_c;
			elap_s34 <= elap_c;
			den_s34  <= den_c;
			pos_s34  <= pos_s33;
		end
	end

	// ---------------- progress divide, one bit per stage ----------------
	logic [18:0]      pd_rem_s [16];
	logic [15:0]      pd_quo_s [16];
	logic [18:0]      pd_den_s [16];
	gsbo_pkg::phase_t pd_ph_s  [16];
	gsbo_pkg::glyph_t pd_pos_s [16];

	for (genvar j = 0; j < 16; j++) begin : g_pdiv
		logic [18:0]      rem_in;
		logic [15:0]      quo_in;
		logic [18:0]      den_in;
		gsbo_pkg::phase_t ph_in;
		gsbo_pkg::glyph_t pos_in;
		logic [19:0]      trial;
		if (j == 0) begin : g_head
			assign rem_in = elap_s34;
			assign quo_in = '0;
			assign den_in = den_s34;
			assign ph_in  = ph_s34;
			assign pos_in = pos_s34;
		end else begin : g_body
			assign rem_in = pd_rem_s[j-1];
			assign quo_in = pd_quo_s[j-1];
			assign den_in = pd_den_s[j-1];
			assign ph_in  = pd_ph_s[j-1];
			assign pos_in = pd_pos_s[j-1];
		end
		assign trial = {rem_in, 1'b0};
		always_ff @(posedge clk) begin
			if (adv) begin
				if (trial >= {1'b0, den_in}) begin
					pd_rem_s[j] <= 19'(trial - {1'b0, den_in});
					pd_quo_s[j] <= {quo_in[14:0], 1'b1};
				end else begin
					pd_rem_s[j] <= trial[18:0];
					pd_quo_s[j] <= {quo_in[14:0], 1'b0};
				end
				pd_den_s[j] <= den_in;
				pd_ph_s[j]  <= ph_in;
				pd_pos_s[j] <= pos_in;
			end
		end
	end

	// ---------------- stage 51..57: curves and position ----------------
	logic                entering;
	logic [31:0]         kprod;
	logic [16:0]         b_s51;
	logic [KW-1:0]       k_s51;
	gsbo_pkg::phase_t    ph_s51;
	gsbo_pkg::glyph_t    pos_s51;
	logic [16:0]         b_s52;
	logic [16:0]         b2_s52;
	logic [15:0]         sn_s52;
	gsbo_pkg::phase_t    ph_s52;
	gsbo_pkg::glyph_t    pos_s52;
	logic [16:0]         b2_s53;
	logic [16:0]         b3_s53;
	logic [15:0]         sn_s53;
	gsbo_pkg::phase_t    ph_s53;
	gsbo_pkg::glyph_t    pos_s53;
	logic [35:0]         prod1_s54;
	logic [35:0]         prod2_s54;
	logic [50:0]         hop_s54;
	logic [16:0]         b3_s54;
	gsbo_pkg::phase_t    ph_s54;
	gsbo_pkg::glyph_t    pos_s54;
	logic signed [37:0]  f_s55;
	logic [50:0]         hop_s55;
	gsbo_pkg::phase_t    ph_s55;
	gsbo_pkg::glyph_t    pos_s55;
	logic [31:0]         pl_s56;
	logic signed [32:0]  ph_prod_s56;
	logic signed [55:0]  y_s56;
	gsbo_pkg::phase_t    ph_s56;
	logic [12:0]         gx_s56;
	logic signed [55:0]  x_s57;
	logic signed [55:0]  y_s57;
	gsbo_pkg::phase_t    ph_s57;
	logic signed [37:0]  v_c;
	logic                flip_c;
	logic [33:0]         sq_c;
	logic [33:0]         cu_c;

	assign entering = (pd_ph_s[15] == gsbo_pkg::PH_ENTER);
	assign kprod    = 32'(pd_quo_s[15]) * 32'(SINE_ENTRIES);
	assign sq_c     = 34'(b_s51) * 34'(b_s51) + 34'd32768;
	assign cu_c     = 34'(b2_s52) * 34'(b_s52) + 34'd32768;

	// Pick the signed slide factor for the phase
	always_comb begin
		v_c    = '0;
		flip_c = 1'b0;
		case (ph_s54)
			gsbo_pkg::PH_WAIT: begin
				v_c    = 38'sh1_0000_0000;
				flip_c = !cfg_dir_q;
			end
			gsbo_pkg::PH_ENTER: begin
				v_c    = $signed({2'b00, prod1_s54}) - $signed({2'b00, prod2_s54});
				flip_c = !cfg_dir_q;
			end
			gsbo_pkg::PH_EXIT: begin
				v_c    = $signed({5'd0, b3_s54, 16'd0});
				flip_c = cfg_dir_q;
			end
			gsbo_pkg::PH_GONE: begin
				v_c    = 38'sh1_0000_0000;
				flip_c = cfg_dir_q;
			end
			default: begin
				v_c    = '0;
				flip_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Curve base and sine index
			b_s51   <= entering ? 17'(17'h10000 - 17'(pd_quo_s[15])) : 17'(pd_quo_s[15]);
			k_s51   <= kprod[16 +: KW];
			ph_s51  <= pd_ph_s[15];
			pos_s51 <= pd_pos_s[15];
			// Square and sine lookup
			b_s52   <= b_s51;
			b2_s52  <= 17'(sq_c >> 16);
			sn_s52  <= (ph_s51 == gsbo_pkg::PH_ENTER) ? sine_rom[k_s51] : 16'd0;
			ph_s52  <= ph_s51;
			pos_s52 <= pos_s51;
			// Cube
			b2_s53  <= b2_s52;
			b3_s53  <= 17'(cu_c >> 16);
			sn_s53  <= sn_s52;
			ph_s53  <= ph_s52;
			pos_s53 <= pos_s52;
			// Back-ease terms and vertical hop
			prod1_s54 <= 36'(20'(c1_q) + 20'h10000) * 36'(b3_s53);
			prod2_s54 <= 36'(c1_q) * 36'(b2_s53);
			hop_s54   <= 51'(hk_q) * 51'(sn_s53);
			b3_s54    <= b3_s53;
			ph_s54    <= ph_s53;
			pos_s54   <= pos_s53;
			// Signed slide factor, Q32
			f_s55   <= flip_c ? -v_c : v_c;
			hop_s55 <= hop_s54;
			ph_s55  <= ph_s54;
			pos_s55 <= pos_s54;
			// Width times factor in two partial products
			pl_s56      <= 32'(cfg_width_q) * 32'(f_s55[18:0]);
			ph_prod_s56 <= $signed({1'b0, cfg_width_q}) * $signed(f_s55[37:19]);
			y_s56       <= $signed({4'd0, pos_s55.gy, 39'd0}) - $signed({5'd0, hop_s55});
			ph_s56      <= ph_s55;
			gx_s56      <= pos_s55.gx;
			// Sum into Q32 pixels
			x_s57  <= $signed({11'd0, gx_s56, 32'd0}) + (56'(ph_prod_s56) <<< 19)
				+ $signed({24'd0, pl_s56});
			y_s57  <= y_s56;
			ph_s57 <= ph_s56;
		end
	end

	// Round and saturate into the output buffer
	always_comb begin
		res_c.pos_x = 15'(round_sat(x_s57, 32, -56'sd16384, 56'sd16383));
		res_c.pos_y = 14'(round_sat(y_s57, 39, -56'sd8192, 56'sd8191));
		res_c.phase = ph_s57;
	end

	// ---------------- output buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				fcnt_q <= fcnt_q + 2'd1;
			end else if (pop && !push) begin
				fcnt_q <= fcnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= res_c;
		end
	end

	assign out_valid = (fcnt_q != 2'd0);
	assign pos_x     = fifo_q[rptr_q].pos_x;
	assign pos_y     = fifo_q[rptr_q].pos_y;
	assign phase     = fifo_q[rptr_q].phase;

	// ---------------- assertions ----------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(fcnt_q == 2'd2 && !out_ready) |-> !push)
		else $error("output buffer overrun");

	a_setup_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("request accepted during timing setup");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (phase <= 3'(gsbo_pkg::PH_GONE)))
		else $error("phase out of range");

endmodule
